// ===== design/etws_pkg.sv =====
`timescale 1ns / 1ps
package etws_pkg;

    localparam int WEIGHT_W = 11;
    // wide enough for the largest store times the largest weight
    localparam int SUM_W    = 28;
    localparam int IDX_W    = 17;
    localparam int TOT_OUT_W = 21;
    localparam int CUT_OUT_W = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 104;

    typedef struct packed {
        logic             v;
        logic             first;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_rd;

    typedef struct packed {
        logic             v;
        logic [SUM_W-1:0] p0;
        logic [SUM_W-1:0] p1;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cand;

    typedef struct packed {
        logic             v;
        logic [SUM_W-1:0] spread;
        logic [SUM_W-1:0] p0;
        logic [SUM_W-1:0] p1;
        logic [SUM_W-1:0] p2;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_eval;

    typedef struct packed {
        logic [SUM_W-1:0] spread;
        logic [SUM_W-1:0] p0;
        logic [SUM_W-1:0] p1;
        logic [SUM_W-1:0] p2;
        logic [IDX_W-1:0] cut1;
        logic [IDX_W-1:0] cut2;
    } t_best;

endpackage

// ===== design/etws_ram.sv =====
`timescale 1ns / 1ps
module etws_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/etws_acc_cell.sv =====
`timescale 1ns / 1ps
module etws_acc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_init,
    input  etws_pkg::t_rd                  i_rd,
    input  logic [etws_pkg::WEIGHT_W-1:0]  i_data,
    output etws_pkg::t_cand                o_cand
);

    logic [etws_pkg::SUM_W-1:0] r_p0;
    logic [etws_pkg::SUM_W-1:0] r_p1;
    etws_pkg::t_cand            r_cand;
    logic [etws_pkg::SUM_W-1:0] n_p1;

    assign n_p1 = r_p1 + etws_pkg::SUM_W'(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.v <= 1'b0;
        end else if (i_init) begin
            r_p0     <= '0;
            r_p1     <= '0;
            r_cand.v <= 1'b0;
        end else if (i_rd.v) begin
            if (i_rd.first) begin
                // new row: item i joins part one
                r_p0     <= r_p0 + etws_pkg::SUM_W'(i_data);
                r_p1     <= '0;
                r_cand.v <= 1'b0;
            end else begin
                r_p1      <= n_p1;
                r_cand.v  <= 1'b1;
                r_cand.p0 <= r_p0;
                r_cand.p1 <= n_p1;
                r_cand.i  <= i_rd.i;
                r_cand.j  <= i_rd.j;
            end
        end else begin
            r_cand.v <= 1'b0;
        end
    end

    assign o_cand = r_cand;

endmodule

// ===== design/etws_spread_cell.sv =====
`timescale 1ns / 1ps
module etws_spread_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [etws_pkg::SUM_W-1:0] i_total,
    input  etws_pkg::t_cand            i_cand,
    output etws_pkg::t_eval            o_eval,
    output logic                       o_busy
);

    etws_pkg::t_eval            r_s1;
    etws_pkg::t_eval            r_s2;
    logic [etws_pkg::SUM_W-1:0] w_max;
    logic [etws_pkg::SUM_W-1:0] w_min;
    logic [etws_pkg::SUM_W-1:0] w_m01;
    logic [etws_pkg::SUM_W-1:0] w_n01;

    always_comb begin
        w_m01 = (r_s1.p0 > r_s1.p1) ? r_s1.p0 : r_s1.p1;
        w_n01 = (r_s1.p0 < r_s1.p1) ? r_s1.p0 : r_s1.p1;
        w_max = (w_m01 > r_s1.p2) ? w_m01 : r_s1.p2;
        w_min = (w_n01 < r_s1.p2) ? w_n01 : r_s1.p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
            r_s2.v <= 1'b0;
        end else begin
            r_s1.v      <= i_cand.v;
            r_s1.spread <= '0;
            r_s1.p0     <= i_cand.p0;
            r_s1.p1     <= i_cand.p1;
            r_s1.p2     <= i_total - i_cand.p0 - i_cand.p1;
            r_s1.i      <= i_cand.i;
            r_s1.j      <= i_cand.j;
            r_s2.v      <= r_s1.v;
            r_s2.spread <= w_max - w_min;
            r_s2.p0     <= r_s1.p0;
            r_s2.p1     <= r_s1.p1;
            r_s2.p2     <= r_s1.p2;
            r_s2.i      <= r_s1.i;
            r_s2.j      <= r_s1.j;
        end
    end

    assign o_eval = r_s2;
    assign o_busy = r_s1.v | r_s2.v;

endmodule

// ===== design/etws_best_cell.sv =====
`timescale 1ns / 1ps
module etws_best_cell (
    input  logic                          i_clk,
    input  logic                          i_init,
    input  logic [etws_pkg::SUM_W-1:0]    i_total,
    input  logic [etws_pkg::WEIGHT_W-1:0] i_w0,
    input  etws_pkg::t_eval               i_eval,
    output etws_pkg::t_best               o_best
);

    etws_pkg::t_best r_best;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            // no cut pair yet: item 0 alone in part one, the rest in part three
            r_best.spread <= i_total;
            r_best.p0     <= etws_pkg::SUM_W'(i_w0);
            r_best.p1     <= '0;
            r_best.p2     <= i_total - etws_pkg::SUM_W'(i_w0);
            r_best.cut1   <= '0;
            r_best.cut2   <= '0;
        end else if (i_eval.v && (i_eval.spread < r_best.spread)) begin
            r_best.spread <= i_eval.spread;
            r_best.p0     <= i_eval.p0;
            r_best.p1     <= i_eval.p1;
            r_best.p2     <= i_eval.p2;
            r_best.cut1   <= i_eval.i;
            r_best.cut2   <= i_eval.j;
        end
    end

    assign o_best = r_best;

endmodule

// ===== design/exhaustive_three_way_split_top.sv =====
`timescale 1ns / 1ps
// three-way split search over a loaded sequence of page counts
// input stream: tdata[10:0] page count, tlast marks the final item of a sequence.
// while loading, items are stored one per cycle into a weight memory of MAX_ITEMS
// entries; items that arrive with the memory full are dropped and flagged.
// after the tlast transaction the block stops accepting input and walks every
// cut pair (i, j) through a chain of cells: accumulate, part-three/spread, best.
// one read per cycle, a row start or a cut pair, enters the chain from the single
// memory read port; a sequence of fewer than three items skips the search.
// output stream: one transaction per sequence, tdata holds the three part
// totals, both cuts and the best spread; tuser[0] is the overflow flag.
// the result is held in an output register until taken; input stays stalled
// while the receiver holds tready low, and loading resumes once it is taken.
// synchronous active-low reset clears the item count, grand total and flag;
// the weight memory is not cleared, only entries of the current sequence are read.
module exhaustive_three_way_split_top #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [etws_pkg::IN_DATA_W-1:0]     i_s_tdata,  // [10:0] page_count
    input  logic                               i_s_tlast,  // last_item
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [20:0] first_total, [41:21] second_total, [62:42] third_total,
    // [72:63] first_cut, [82:73] second_cut, [103:83] best_spread
    output logic [etws_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [0:0]                         o_m_tuser   // [0] overflow_flag
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {S_LOAD, S_SETUP, S_SEARCH, S_DRAIN, S_OUT} t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_count;
    logic [etws_pkg::SUM_W-1:0]      r_total;
    logic [etws_pkg::WEIGHT_W-1:0]   r_w0;
    logic                            r_drop;
    logic [CNT_W-1:0]                r_i;
    logic [CNT_W-1:0]                r_j;
    etws_pkg::t_rd                   r_rd;
    logic [etws_pkg::OUT_DATA_W-1:0] r_odata;
    logic                            r_ouser;

    logic                            w_acc;
    logic                            w_full;
    logic                            w_init;
    logic [etws_pkg::WEIGHT_W-1:0]   w_weight;
    logic [etws_pkg::WEIGHT_W-1:0]   w_rdata;
    etws_pkg::t_cand                 w_cand;
    etws_pkg::t_eval                 w_eval;
    etws_pkg::t_best                 w_best;
    logic                            w_busy;

    assign w_weight = i_s_tdata[etws_pkg::WEIGHT_W-1:0];
    assign w_acc    = i_s_tvalid && o_s_tready;
    assign w_full   = (r_count == CNT_W'(MAX_ITEMS));
    assign w_init   = (r_state == S_SETUP);

    etws_ram #(.WIDTH(etws_pkg::WEIGHT_W), .DEPTH(MAX_ITEMS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && !w_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_weight),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (w_rdata)
    );

    etws_acc_cell u_acc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_init (w_init),
        .i_rd   (r_rd),
        .i_data (w_rdata),
        .o_cand (w_cand)
    );

    etws_spread_cell u_spread (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_total(r_total),
        .i_cand (w_cand),
        .o_eval (w_eval),
        .o_busy (w_busy)
    );

    etws_best_cell u_best (
        .i_clk  (i_clk),
        .i_init (w_init),
        .i_total(r_total),
        .i_w0   (r_w0),
        .i_eval (w_eval),
        .o_best (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
            r_rd.v  <= 1'b0;
        end else begin
            r_rd.v <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                            r_total <= r_total + etws_pkg::SUM_W'(w_weight);
                            if (r_count == '0) begin
                                r_w0 <= w_weight;
                            end
                        end
                        if (i_s_tlast) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_state <= (r_count >= CNT_W'(3)) ? S_SEARCH : S_DRAIN;
                end
                S_SEARCH: begin
                    r_rd.v     <= 1'b1;
                    r_rd.first <= (r_j == r_i);
                    r_rd.i     <= etws_pkg::IDX_W'(r_i);
                    r_rd.j     <= etws_pkg::IDX_W'(r_j);
                    if (r_j + CNT_W'(2) == r_count) begin
                        if (r_i + CNT_W'(3) == r_count) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + CNT_W'(1);
                            r_j <= r_i + CNT_W'(1);
                        end
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_rd.v && !w_cand.v && !w_busy && !w_eval.v) begin
                        r_odata <= {w_best.spread[etws_pkg::TOT_OUT_W-1:0],
                                    w_best.cut2[etws_pkg::CUT_OUT_W-1:0],
                                    w_best.cut1[etws_pkg::CUT_OUT_W-1:0],
                                    w_best.p2[etws_pkg::TOT_OUT_W-1:0],
                                    w_best.p1[etws_pkg::TOT_OUT_W-1:0],
                                    w_best.p0[etws_pkg::TOT_OUT_W-1:0]};
                        r_ouser <= r_drop;
                        r_count <= '0;
                        r_total <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_s_tready   = (r_state == S_LOAD);
    assign o_m_tvalid   = (r_state == S_OUT);
    assign o_m_tdata    = r_odata;
    assign o_m_tuser[0] = r_ouser;

endmodule

// ===== design/etws_checker.sv =====
`timescale 1ns / 1ps
module etws_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         i_s_tlast,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata
);

    logic [22:0] w_sum;
    assign w_sum = 23'(o_m_tdata[20:0]) + 23'(o_m_tdata[41:21]) + 23'(o_m_tdata[62:42]);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("loading while a result is pending");

    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken during search");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |=> o_s_tready)
        else $error("loading did not resume after result");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 23'(o_m_tdata[103:83]) <= w_sum)
        else $error("spread above grand total");

endmodule

bind exhaustive_three_way_split_top etws_checker u_etws_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== test/exhaustive_three_way_split_top_tb.sv =====
`timescale 1ns / 1ps
module exhaustive_three_way_split_top_tb;

    localparam int CAP       = 1024;
    localparam int NUM_ITEMS = 1900;
    localparam int IDLE_MAX  = 2000000;

    localparam int WEIGHT_W   = etws_pkg::WEIGHT_W;
    localparam int TOT_OUT_W  = etws_pkg::TOT_OUT_W;
    localparam int CUT_OUT_W  = etws_pkg::CUT_OUT_W;
    localparam int IN_DATA_W  = etws_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = etws_pkg::OUT_DATA_W;

    typedef struct packed {
        logic [TOT_OUT_W-1:0] spread;
        logic [CUT_OUT_W-1:0] cut2;
        logic [CUT_OUT_W-1:0] cut1;
        logic [TOT_OUT_W-1:0] tot2;
        logic [TOT_OUT_W-1:0] tot1;
        logic [TOT_OUT_W-1:0] tot0;
    } t_split;

    typedef struct {
        t_split split;
        logic   ovf;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0]            o_m_tuser;

    exhaustive_three_way_split_top #(.MAX_ITEMS(CAP)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    int unsigned page_mem[CAP];
    int unsigned page_cnt;
    longint unsigned page_sum;
    bit          page_drop;

    t_result split_q[$];
    int  errors;
    int  splits_seen;
    int  items_sent;
    int  idle_cycles = 0;
    bit  stall_mode = 1'b0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0d want %0d (split %0d)", what, got, want,
                 splits_seen);
        errors++;
    endtask

    // exhaustive cut search on the stored sequence
    function automatic t_result split_search();
        t_result r;
        longint unsigned best, p0, p1, p2, hi, lo, sp;
        longint unsigned pt[3];
        int c1, c2;
        best = page_sum;
        c1 = 0;
        c2 = 0;
        p0 = 0;
        pt = '{0, 0, 0};
        if (page_cnt >= 3) begin
            for (int i = 0; i + 2 < page_cnt; i++) begin
                p0 += 64'(page_mem[i]);
                p1 = 0;
                for (int j = i + 1; j + 1 < page_cnt; j++) begin
                    p1 += 64'(page_mem[j]);
                    p2 = page_sum - p0 - p1;
                    hi = p0 > p1 ? p0 : p1;
                    hi = hi > p2 ? hi : p2;
                    lo = p0 < p1 ? p0 : p1;
                    lo = lo < p2 ? lo : p2;
                    sp = hi - lo;
                    if (sp < best) begin
                        best = sp;
                        c1 = i;
                        c2 = j;
                    end
                end
            end
        end
        for (int i = 0; i < page_cnt; i++) begin
            if (i <= c1) pt[0] += 64'(page_mem[i]);
            else if (i <= c2) pt[1] += 64'(page_mem[i]);
            else pt[2] += 64'(page_mem[i]);
        end
        r.split.tot0 = pt[0][TOT_OUT_W-1:0];
        r.split.tot1 = pt[1][TOT_OUT_W-1:0];
        r.split.tot2 = pt[2][TOT_OUT_W-1:0];
        r.split.cut1 = c1[CUT_OUT_W-1:0];
        r.split.cut2 = c2[CUT_OUT_W-1:0];
        r.split.spread = best[TOT_OUT_W-1:0];
        r.ovf = page_drop;
        return r;
    endfunction

    function automatic void load_page(input logic [WEIGHT_W-1:0] w, input logic last);
        if (page_cnt < CAP) begin
            page_mem[page_cnt] = 32'(w);
            page_cnt++;
            page_sum += 64'(w);
        end else begin
            page_drop = 1'b1;
        end
        if (last) begin
            split_q.push_back(split_search());
            page_cnt = 0;
            page_sum = 0;
            page_drop = 1'b0;
        end
    endfunction

    // send one transaction, with a random gap first when asked
    task automatic send_page(input logic [WEIGHT_W-1:0] w, input logic last,
                             input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'(w);
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        load_page(w, last);
        items_sent++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (split_q.size() != 0);
    endtask

    // sequence of given length with random content; burst-style gaps
    task automatic send_sequence(input int len, input int wmax);
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            int gap;
            gap = 0;
            if (burst == 0) begin
                gap = $urandom_range(1, 4);
                burst = $urandom_range(1, 12);
            end
            burst--;
            send_page(WEIGHT_W'($urandom_range(0, wmax)), k == len - 1, gap);
        end
    endtask

    // receiver: alternates between free running and random stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        i_m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("watchdog expired");
                $display("exhaustive_three_way_split_top_tb failed");
                $finish;
            end
        end
        if (o_m_tvalid && i_m_tready) begin
            if (split_q.size() == 0) begin
                $display("unexpected result transaction");
                errors++;
            end else begin
                t_result want;
                t_split got;
                want = split_q.pop_front();
                got = t_split'(o_m_tdata);
                if (got.tot0 != want.split.tot0)
                    report_mismatch("first_total", got.tot0, want.split.tot0);
                if (got.tot1 != want.split.tot1)
                    report_mismatch("second_total", got.tot1, want.split.tot1);
                if (got.tot2 != want.split.tot2)
                    report_mismatch("third_total", got.tot2, want.split.tot2);
                if (got.cut1 != want.split.cut1)
                    report_mismatch("first_cut", got.cut1, want.split.cut1);
                if (got.cut2 != want.split.cut2)
                    report_mismatch("second_cut", got.cut2, want.split.cut2);
                if (got.spread != want.split.spread)
                    report_mismatch("best_spread", got.spread, want.split.spread);
                if (o_m_tuser[0] != want.ovf)
                    report_mismatch("overflow_flag", o_m_tuser[0], want.ovf);
            end
            splits_seen++;
        end
    end

    // directed table: weight, last, expected totals/cuts/spread where obvious
    typedef struct {
        logic [WEIGHT_W-1:0] w;
        logic                last;
        bit                  typed;
        t_split              split;
    } t_row;

    t_row dir_tab[$];

    function automatic t_row mk(input int w, input bit last, input bit typed = 0,
                                input int t0 = 0, input int t1 = 0, input int t2 = 0,
                                input int c1 = 0, input int c2 = 0, input int sp = 0);
        t_row r;
        r.w = WEIGHT_W'(w);
        r.last = last;
        r.typed = typed;
        r.split = '{spread: TOT_OUT_W'(sp), cut2: CUT_OUT_W'(c2), cut1: CUT_OUT_W'(c1),
                    tot2: TOT_OUT_W'(t2), tot1: TOT_OUT_W'(t1), tot0: TOT_OUT_W'(t0)};
        return r;
    endfunction

    initial begin
        t_result want;
        errors = 0;
        splits_seen = 0;
        items_sent = 0;
        page_cnt = 0;
        page_sum = 0;
        page_drop = 1'b0;
        // single item, both extremes
        dir_tab.push_back(mk(0, 1, 1));
        dir_tab.push_back(mk(2047, 1, 1, 2047, 0, 0, 0, 0, 2047));
        // two items: item 0 is part one, the rest part three
        dir_tab.push_back(mk(5, 0));
        dir_tab.push_back(mk(9, 1, 1, 5, 0, 9, 0, 0, 14));
        // three equal items split perfectly
        dir_tab.push_back(mk(2047, 0));
        dir_tab.push_back(mk(2047, 0));
        dir_tab.push_back(mk(2047, 1, 1, 2047, 2047, 2047, 0, 1, 0));
        // all zero: no improvement on the grand total
        dir_tab.push_back(mk(0, 0));
        dir_tab.push_back(mk(0, 0));
        dir_tab.push_back(mk(0, 0));
        dir_tab.push_back(mk(0, 1, 1));
        // uneven sequence, predictor only
        dir_tab.push_back(mk(1024, 0));
        dir_tab.push_back(mk(1, 0));
        dir_tab.push_back(mk(1365, 0));
        dir_tab.push_back(mk(682, 0));
        dir_tab.push_back(mk(2046, 1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].last && dir_tab[k].typed) begin
                // look ahead with the final item included, then take it back out
                load_page(dir_tab[k].w, 1'b0);
                want = split_search();
                page_cnt--;
                page_sum -= 64'(dir_tab[k].w);
            end
            send_page(dir_tab[k].w, dir_tab[k].last, $urandom_range(0, 2));
            if (dir_tab[k].last && dir_tab[k].typed && want.split != dir_tab[k].split) begin
                $display("directed row %0d disagrees with predictor", k);
                errors++;
            end
        end
        drain_results();

        // full store plus drops, the first four at the largest weight, the rest random
        for (int k = 0; k < CAP + 3; k++)
            send_page(WEIGHT_W'(k < 4 ? 2047 : $urandom_range(0, 2047)),
                      k == CAP + 2, 0);
        drain_results();

        // random sequences, mostly short so the quadratic search stays quick
        while (items_sent < NUM_ITEMS) begin
            int len;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 2);
                1: len = $urandom_range(30, 60);
                default: len = $urandom_range(3, 12);
            endcase
            send_sequence(len, $urandom_range(0, 1) ? 2047 : 15);
            if ($urandom_range(0, 15) == 0) drain_results();
        end
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("sent %0d page counts, checked %0d split results", items_sent, splits_seen);
        $display("covered short sequences, full store with dropped items and random weights");
        if (errors == 0 && split_q.size() == 0)
            $display("exhaustive_three_way_split_top_tb passed");
        else
            $display("exhaustive_three_way_split_top_tb failed");
        $finish;
    end

endmodule
